[rtl/ogru_pkg.sv]
// shared types and constants for the occupancy grid ray update block
// used by ogru_div, occupancy_grid_ray_update and the testbench; no other dependencies
package ogru_pkg;

  localparam int GRID_SIDE  = 256;
  localparam int GRID_W     = $clog2(GRID_SIDE);
  localparam int HALF_SIDE  = GRID_SIDE / 2;
  localparam int CELL_COUNT = GRID_SIDE * GRID_SIDE;
  localparam int ADDR_W     = $clog2(CELL_COUNT);

  // divider operand width: covers 2*x, the square root of 4*s and 2*n*c
  localparam int DIV_W = 18;
  localparam int MUL_W = 18;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_POINT = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [1:0] CELL_UNKNOWN  = 2'd0;
  localparam logic [1:0] CELL_FREE     = 2'd1;
  localparam logic [1:0] CELL_OCCUPIED = 2'd2;

  localparam logic [1:0] CFG_CELL_SIZE     = 2'd0;
  localparam logic [1:0] CFG_PILLAR_RADIUS = 2'd1;

  // angle window boundary directions in q15 (cos, sin)
  localparam logic signed [MUL_W-1:0] WIN_LO_C [0:2] = '{18'sd26086, -18'sd26252, 18'sd19061};
  localparam logic signed [MUL_W-1:0] WIN_LO_S [0:2] = '{18'sd19831, -18'sd19611, -18'sd26654};
  localparam logic signed [MUL_W-1:0] WIN_HI_C [0:2] = '{-18'sd32768, -18'sd19284, 18'sd26086};
  localparam logic signed [MUL_W-1:0] WIN_HI_S [0:2] = '{18'sd52, -18'sd26493, -18'sd19831};

  typedef struct packed {
    logic                    start;
    logic signed [DIV_W-1:0] num;
    logic [DIV_W-1:0]        den;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [DIV_W-1:0] quo;
    logic [DIV_W-1:0]        rem;
  } div_rsp_t;

endpackage

[rtl/ogru_div.sv]
// sequential floor divider: signed numerator, unsigned nonzero denominator
// one quotient bit per cycle; depends on ogru_pkg
module ogru_div (
  input  logic              clk,
  input  logic              rst_n,
  input  ogru_pkg::div_req_t req,
  output ogru_pkg::div_rsp_t rsp
);
  import ogru_pkg::*;

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic             neg_r;
  logic [DIV_W-1:0] quo_r;
  logic [DIV_W-1:0] rem_r;
  logic [DIV_W-1:0] den_r;

  logic [DIV_W:0] rem_sh;
  logic [DIV_W:0] rem_dif;
  logic           ge;

  assign rem_sh  = {rem_r, quo_r[DIV_W-1]};
  assign rem_dif = rem_sh - {1'b0, den_r};
  assign ge      = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIV_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      neg_r <= req.num[DIV_W-1];
      quo_r <= req.num[DIV_W-1] ? DIV_W'(-req.num) : DIV_W'(req.num);
      rem_r <= '0;
      den_r <= req.den;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIV_W-2:0], ge};
      rem_r <= ge ? rem_dif[DIV_W-1:0] : rem_sh[DIV_W-1:0];
    end
  end

  // magnitudes to floor quotient and nonnegative remainder
  always_comb begin
    rsp.done = done_r;
    if (neg_r && (rem_r != '0)) begin
      rsp.quo = -$signed(quo_r) - DIV_W'(1);
      rsp.rem = den_r - rem_r;
    end else if (neg_r) begin
      rsp.quo = -$signed(quo_r);
      rsp.rem = '0;
    end else begin
      rsp.quo = $signed(quo_r);
      rsp.rem = rem_r;
    end
  end

endmodule

[rtl/occupancy_grid_ray_update.sv]
// occupancy grid ray update: top level with sequencer, grid memory and shared multiplier
// depends on ogru_pkg and ogru_div
//
// usage:
// - input channel (in_valid/in_ready) takes one word: op, x_mm, y_mm, cell_index.
//   op clear sets all 65536 cells unknown, op point walks a ray from the grid centre
//   to (x_mm, y_mm) marking cells free and then marks the end cell, op read returns one
//   cell on the output channel (out_valid/out_ready), op 3 does nothing.
// - the block takes one word at a time; in_ready is high only while idle.
// - clear: one cell per cycle through the single memory write port.
// - point: n = floor(2*dist/cell) ray samples are written one per cycle; besides the walk
//   it runs the serial divider (five divides at most), the 17-step square root and the
//   window products on the one multiplier.
// - read: the cell goes to rd_data_r in ST_READ, then to the output register in ST_RESP;
//   the result word then waits there while a stalled receiver holds out_ready low, and
//   the next word is taken meanwhile; a second read waits until the first result is taken.
// - after reset a clearing pass over all 65536 cells runs with in_ready low.
// - config writes (cfg_we, cfg_index, cfg_wdata) take effect at once, index 0 cell size,
//   index 1 pillar radius; other indexes are ignored.
module occupancy_grid_ray_update (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [15:0] in_x_mm,
  input  logic [15:0] in_y_mm,
  input  logic [15:0] in_cell_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_cell_value,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_wdata
);
  import ogru_pkg::*;

  typedef enum logic [14:0] {
    ST_IDLE  = 15'b000000000000001,
    ST_CLEAR = 15'b000000000000010,
    ST_MULS  = 15'b000000000000100,
    ST_SQRT  = 15'b000000000001000,
    ST_DIVN  = 15'b000000000010000,
    ST_MULNC = 15'b000000000100000,
    ST_DIVX  = 15'b000000001000000,
    ST_DIVY  = 15'b000000010000000,
    ST_WALK  = 15'b000000100000000,
    ST_OWNX  = 15'b000001000000000,
    ST_OWNY  = 15'b000010000000000,
    ST_WIN   = 15'b000100000000000,
    ST_MARK  = 15'b001000000000000,
    ST_READ  = 15'b010000000000000,
    ST_RESP  = 15'b100000000000000
  } state_t;

  localparam int GC_W = 20;

  state_t state_r, state_nxt;

  logic [9:0]  cell_size_r;
  logic [11:0] pillar_r;
  logic [9:0]  c_eff;

  logic signed [15:0] x_r, y_r;
  logic [15:0]        idx_r;

  logic [2:0]  step_r;
  logic [1:0]  win_r;
  logic        hit_r;
  logic [ADDR_W-1:0] clr_cnt_r;

  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [2*MUL_W-1:0] mul_p_r;

  logic [31:0] s_r;
  logic [23:0] rr_r;
  logic [33:0] sq_v_r, sq_root_r, sq_bit_r, sq_cand;

  logic [16:0]      n_r, i_r;
  logic [DIV_W-1:0] d_r;
  logic signed [DIV_W-1:0] qa_x_r, qa_y_r;
  logic [DIV_W-1:0]        ra_x_r, ra_y_r;
  logic signed [GC_W-1:0]  qx_r, qy_r, own_x_r, own_y_r;
  logic [DIV_W-1:0]        rx_r, ry_r;
  logic [DIV_W:0]          rx_sum, ry_sum;
  logic                    x_wrap, y_wrap;

  logic signed [2*MUL_W:0] c1_r, c2_r, c2_fin;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [1:0]        mem [CELL_COUNT];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [1:0]        mem_wdata;
  logic [1:0]        rd_data_r;

  logic       out_valid_r;
  logic [1:0] out_value_r;

  logic       own_free;

  function automatic logic in_map(logic signed [GC_W-1:0] gx, logic signed [GC_W-1:0] gy);
    return !gx[GC_W-1] && ($unsigned(gx) < GC_W'(GRID_SIDE))
        && !gy[GC_W-1] && ($unsigned(gy) < GC_W'(GRID_SIDE));
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(logic signed [GC_W-1:0] gx,
                                                 logic signed [GC_W-1:0] gy);
    return ADDR_W'(gy[GRID_W-1:0]) * ADDR_W'(GRID_SIDE) + ADDR_W'(gx[GRID_W-1:0]);
  endfunction

  assign c_eff    = (cell_size_r == '0) ? 10'd1 : cell_size_r;
  assign in_ready = (state_r == ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_cell_value = out_value_r;

  ogru_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_size_r <= 10'd5;
      pillar_r    <= 12'd300;
    end else if (cfg_we) begin
      if (cfg_index == CFG_CELL_SIZE)
        cell_size_r <= cfg_wdata[9:0];
      else if (cfg_index == CFG_PILLAR_RADIUS)
        pillar_r <= cfg_wdata;
    end
  end

  // shared multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_MULS: begin
        if (step_r == 3'd0) begin
          mul_a = MUL_W'(x_r);
          mul_b = MUL_W'(x_r);
        end else if (step_r == 3'd1) begin
          mul_a = MUL_W'(y_r);
          mul_b = MUL_W'(y_r);
        end else begin
          mul_a = $signed({6'b0, pillar_r});
          mul_b = $signed({6'b0, pillar_r});
        end
      end
      ST_MULNC: begin
        mul_a = $signed({1'b0, n_r});
        mul_b = $signed({8'b0, c_eff});
      end
      ST_WIN: begin
        unique case (step_r)
          3'd0: begin
            mul_a = WIN_LO_C[win_r];
            mul_b = MUL_W'(y_r);
          end
          3'd1: begin
            mul_a = WIN_LO_S[win_r];
            mul_b = MUL_W'(x_r);
          end
          3'd2: begin
            mul_a = WIN_HI_S[win_r];
            mul_b = MUL_W'(x_r);
          end
          3'd3: begin
            mul_a = WIN_HI_C[win_r];
            mul_b = MUL_W'(y_r);
          end
          default: begin
            mul_a = '0;
            mul_b = '0;
          end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p_r <= mul_a * mul_b;
  end

  assign sq_cand = sq_root_r + sq_bit_r;
  assign rx_sum  = {1'b0, rx_r} + {1'b0, ra_x_r};
  assign ry_sum  = {1'b0, ry_r} + {1'b0, ra_y_r};
  assign x_wrap  = rx_sum >= {1'b0, d_r};
  assign y_wrap  = ry_sum >= {1'b0, d_r};
  assign c2_fin  = c2_r - (2*MUL_W+1)'(mul_p_r);

  assign own_free = (s_r < {8'b0, rr_r}) && hit_r && !((x_r == '0) && (y_r == '0));

  // sequencer
  always_comb begin
    state_nxt = state_r;
    div_req   = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          priority case (in_op)
            OP_CLEAR: state_nxt = ST_CLEAR;
            OP_POINT: state_nxt = ST_MULS;
            OP_READ:  state_nxt = ST_READ;
            default:  state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_CLEAR: begin
        if (clr_cnt_r == ADDR_W'(CELL_COUNT - 1))
          state_nxt = ST_IDLE;
      end
      ST_MULS: begin
        if (step_r == 3'd3)
          state_nxt = ST_SQRT;
      end
      ST_SQRT: begin
        if (sq_bit_r == '0) begin
          div_req.start = 1'b1;
          div_req.den   = DIV_W'(c_eff);
          if (s_r == '0) begin
            div_req.num = DIV_W'(x_r);
            state_nxt   = ST_OWNX;
          end else begin
            div_req.num = $signed(DIV_W'(sq_root_r));
            state_nxt   = ST_DIVN;
          end
        end
      end
      ST_DIVN: begin
        if (div_rsp.done) begin
          if (div_rsp.quo == '0) begin
            div_req.start = 1'b1;
            div_req.num   = DIV_W'(x_r);
            div_req.den   = DIV_W'(c_eff);
            state_nxt     = ST_OWNX;
          end else begin
            state_nxt = ST_MULNC;
          end
        end
      end
      ST_MULNC: begin
        if (step_r == 3'd1) begin
          div_req.start = 1'b1;
          div_req.num   = $signed({x_r[15], x_r, 1'b0});
          div_req.den   = {mul_p_r[DIV_W-2:0], 1'b0};
          state_nxt     = ST_DIVX;
        end
      end
      ST_DIVX: begin
        if (div_rsp.done) begin
          div_req.start = 1'b1;
          div_req.num   = $signed({y_r[15], y_r, 1'b0});
          div_req.den   = d_r;
          state_nxt     = ST_DIVY;
        end
      end
      ST_DIVY: begin
        if (div_rsp.done)
          state_nxt = ST_WALK;
      end
      ST_WALK: begin
        if (i_r == n_r - 1'b1) begin
          div_req.start = 1'b1;
          div_req.num   = DIV_W'(x_r);
          div_req.den   = DIV_W'(c_eff);
          state_nxt     = ST_OWNX;
        end
      end
      ST_OWNX: begin
        if (div_rsp.done) begin
          div_req.start = 1'b1;
          div_req.num   = DIV_W'(y_r);
          div_req.den   = DIV_W'(c_eff);
          state_nxt     = ST_OWNY;
        end
      end
      ST_OWNY: begin
        if (div_rsp.done)
          state_nxt = ST_WIN;
      end
      ST_WIN: begin
        if ((step_r == 3'd4) && (win_r == 2'd2))
          state_nxt = ST_MARK;
      end
      ST_MARK: state_nxt = ST_IDLE;
      ST_READ: state_nxt = ST_RESP;
      ST_RESP: begin
        if (!out_valid_r || out_ready)
          state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n)
      state_r <= ST_CLEAR;
    else
      state_r <= state_nxt;
  end

  // datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      step_r    <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          clr_cnt_r <= '0;
          step_r    <= '0;
          x_r       <= in_x_mm;
          y_r       <= in_y_mm;
          idx_r     <= in_cell_index;
        end
        ST_CLEAR: clr_cnt_r <= clr_cnt_r + 1'b1;
        ST_MULS: begin
          step_r <= step_r + 1'b1;
          if (step_r == 3'd1)
            s_r <= 32'(mul_p_r);
          else if (step_r == 3'd2)
            s_r <= s_r + 32'(mul_p_r);
          else if (step_r == 3'd3) begin
            rr_r      <= 24'(mul_p_r);
            sq_v_r    <= {s_r, 2'b00};
            sq_root_r <= '0;
            sq_bit_r  <= 34'd1 << 32;
          end
        end
        ST_SQRT: begin
          if (sq_bit_r != '0) begin
            if (sq_v_r >= sq_cand) begin
              sq_v_r    <= sq_v_r - sq_cand;
              sq_root_r <= (sq_root_r >> 1) + sq_bit_r;
            end else begin
              sq_root_r <= sq_root_r >> 1;
            end
            sq_bit_r <= sq_bit_r >> 2;
          end
        end
        ST_DIVN: begin
          n_r    <= div_rsp.quo[16:0];
          step_r <= '0;
        end
        ST_MULNC: begin
          step_r <= step_r + 1'b1;
          if (step_r == 3'd1)
            d_r <= {mul_p_r[DIV_W-2:0], 1'b0};
        end
        ST_DIVX: begin
          qa_x_r <= div_rsp.quo;
          ra_x_r <= div_rsp.rem;
        end
        ST_DIVY: begin
          qa_y_r <= div_rsp.quo;
          ra_y_r <= div_rsp.rem;
          // first sample sits at the grid centre with zero remainder
          qx_r   <= GC_W'(HALF_SIDE);
          qy_r   <= GC_W'(HALF_SIDE);
          rx_r   <= '0;
          ry_r   <= '0;
          i_r    <= '0;
        end
        ST_WALK: begin
          i_r  <= i_r + 1'b1;
          qx_r <= qx_r + GC_W'(qa_x_r) + GC_W'(x_wrap);
          qy_r <= qy_r + GC_W'(qa_y_r) + GC_W'(y_wrap);
          rx_r <= x_wrap ? DIV_W'(rx_sum - {1'b0, d_r}) : DIV_W'(rx_sum);
          ry_r <= y_wrap ? DIV_W'(ry_sum - {1'b0, d_r}) : DIV_W'(ry_sum);
        end
        ST_OWNX: own_x_r <= GC_W'(div_rsp.quo) + GC_W'(HALF_SIDE);
        ST_OWNY: begin
          own_y_r <= GC_W'(div_rsp.quo) + GC_W'(HALF_SIDE);
          step_r  <= '0;
          win_r   <= '0;
          hit_r   <= 1'b0;
        end
        ST_WIN: begin
          unique case (step_r)
            3'd1: c1_r <= (2*MUL_W+1)'(mul_p_r);
            3'd2: c1_r <= c1_r - (2*MUL_W+1)'(mul_p_r);
            3'd3: c2_r <= (2*MUL_W+1)'(mul_p_r);
            default: ;
          endcase
          if (step_r == 3'd4) begin
            if (!c1_r[2*MUL_W] && !c2_fin[2*MUL_W])
              hit_r <= 1'b1;
            win_r  <= win_r + 1'b1;
            step_r <= '0;
          end else begin
            step_r <= step_r + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // grid memory write port
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_cnt_r;
    mem_wdata = CELL_UNKNOWN;
    unique case (state_r)
      ST_CLEAR: mem_we = 1'b1;
      ST_WALK: begin
        mem_we    = in_map(qx_r, qy_r);
        mem_waddr = cell_addr(qx_r, qy_r);
        mem_wdata = CELL_FREE;
      end
      ST_MARK: begin
        mem_we    = in_map(own_x_r, own_y_r);
        mem_waddr = cell_addr(own_x_r, own_y_r);
        mem_wdata = own_free ? CELL_FREE : CELL_OCCUPIED;
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we)
      mem[mem_waddr] <= mem_wdata;
    if (state_r == ST_READ)
      rd_data_r <= mem[ADDR_W'(idx_r)];
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_RESP) && (!out_valid_r || out_ready)) begin
      out_valid_r <= 1'b1;
      out_value_r <= (32'(idx_r) < 32'(CELL_COUNT)) ? rd_data_r : CELL_UNKNOWN;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  a_mem_we_state: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_CLEAR) || (state_r == ST_WALK) || (state_r == ST_MARK))
    else $error("grid written outside clear, walk or mark");

  a_read_path: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_op == OP_READ)) |=> (state_r == ST_READ) ##1 (state_r == ST_RESP))
    else $error("read word did not go to the memory read");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> (n_r != '0) && (i_r < n_r))
    else $error("ray walk ran past its sample count");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_DIVN) || (state_r == ST_DIVX) || (state_r == ST_DIVY)
                   || (state_r == ST_OWNX) || (state_r == ST_OWNY))
    else $error("divider finished with no state waiting");

  a_no_lost_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> out_valid_r)
    else $error("pending result dropped");

endmodule

[tb/sv/occupancy_grid_ray_update_test.sv]
`timescale 1ns / 1ps
// self-checking testbench for occupancy_grid_ray_update: drives point, clear, read and op 3 words
// and checks every read against an integer grid predictor kept in a scoreboard class
// depends on ogru_pkg and the rtl of the block
module occupancy_grid_ray_update_test;
  import ogru_pkg::*;

  class grid_scoreboard;
    bit [1:0]    grid_cells [CELL_COUNT];
    int unsigned cell_mm;
    int unsigned pillar_mm;
    bit [1:0]    cell_values_due [$];
    int          touched [$];
    int          errors;

    function new();
      cell_mm = 5;
      pillar_mm = 300;
      foreach (grid_cells[i]) grid_cells[i] = CELL_UNKNOWN;
    endfunction

    function void write_reg(logic [1:0] idx, logic [11:0] val);
      if (idx == CFG_CELL_SIZE) cell_mm = val[9:0];
      else if (idx == CFG_PILLAR_RADIUS) pillar_mm = val;
    endfunction

    function longint floor_div(longint a, longint b);
      longint q;
      q = a / b;
      if ((a % b) != 0 && ((a < 0) != (b < 0))) q--;
      return q;
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function bit in_pillar_window(longint x, longint y);
      longint lo_c [3] = '{26086, -26252, 19061};
      longint lo_s [3] = '{19831, -19611, -26654};
      longint hi_c [3] = '{-32768, -19284, 26086};
      longint hi_s [3] = '{52, -26493, -19831};
      if (x == 0 && y == 0) return 0;
      for (int w = 0; w < 3; w++)
        if (lo_c[w] * y - lo_s[w] * x >= 0 && x * hi_s[w] - y * hi_c[w] >= 0) return 1;
      return 0;
    endfunction

    function void set_cell(longint gx, longint gy, bit [1:0] v);
      int k;
      if (gx < 0 || gx >= GRID_SIDE || gy < 0 || gy >= GRID_SIDE) return;
      k = int'(gy * GRID_SIDE + gx);
      grid_cells[k] = v;
      touched.push_back(k);
      if (touched.size() > 64) void'(touched.pop_front());
    endfunction

    function void mark_ray(longint x, longint y);
      longint c, span, n, den;
      longint unsigned s;
      c = (cell_mm == 0) ? 1 : cell_mm;
      span = GRID_SIDE * c;
      s = x * x + y * y;
      if (s != 0) begin
        n = longint'(int_sqrt(4 * s) / c);
        den = 2 * n * c;
        for (longint i = 0; i < n; i++)
          set_cell(floor_div(2 * i * x + n * span, den),
                   floor_div(2 * i * y + n * span, den), CELL_FREE);
      end
      if (s < pillar_mm * pillar_mm && in_pillar_window(x, y))
        set_cell(floor_div(2 * x + span, 2 * c), floor_div(2 * y + span, 2 * c), CELL_FREE);
      else
        set_cell(floor_div(2 * x + span, 2 * c), floor_div(2 * y + span, 2 * c),
                 CELL_OCCUPIED);
    endfunction

    // takes one accepted input word
    function void note_word(logic [1:0] op, logic [15:0] x, logic [15:0] y,
                            logic [15:0] idx);
      case (op)
        OP_CLEAR: begin
          foreach (grid_cells[i]) grid_cells[i] = CELL_UNKNOWN;
        end
        OP_POINT: mark_ray(longint'($signed(x)), longint'($signed(y)));
        OP_READ: cell_values_due.push_back(grid_cells[idx]);
        default: ;
      endcase
    endfunction

    function void check_result(logic [1:0] got);
      bit [1:0] want;
      if (cell_values_due.size() == 0) begin
        $display("%0t: unexpected result word, cell_value %0d", $time, got);
        errors++;
        return;
      end
      want = cell_values_due.pop_front();
      if (got !== want) begin
        $display("%0t: cell_value mismatch, expected %0d actual %0d", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  localparam int WATCHDOG_LIMIT = 400000;
  localparam int HOLD_CYCLES    = 3000;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [1:0]  in_op = OP_CLEAR;
  logic [15:0] in_x_mm = '0;
  logic [15:0] in_y_mm = '0;
  logic [15:0] in_cell_index = '0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [1:0]  out_cell_value;
  logic        cfg_we = 0;
  logic [1:0]  cfg_index = '0;
  logic [11:0] cfg_wdata = '0;

  grid_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_req = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  occupancy_grid_ray_update dut (.*);

  // receiver: random stalls plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      out_ready = 0;
      hold_left--;
    end else begin
      out_ready = ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_cell_value);
    if (rst_n && ((in_valid && in_ready) || (out_valid && out_ready))) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance, valid left high
  task automatic send_word(logic [1:0] op, logic [15:0] x, logic [15:0] y, logic [15:0] idx);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid = 1;
    in_op = op;
    in_x_mm = x;
    in_y_mm = y;
    in_cell_index = idx;
    forever begin
      @(posedge clk);
      if (in_ready) break;
    end
    sb.note_word(op, x, y, idx);
    @(negedge clk);
  endtask

  // block idle and every read returned
  task automatic drain();
    in_valid = 0;
    forever begin
      @(negedge clk);
      if (sb.cell_values_due.size() == 0 && in_ready) break;
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [11:0] val);
    drain();
    cfg_we = 1;
    cfg_index = idx;
    cfg_wdata = val;
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_we = 0;
  endtask

  function automatic logic [15:0] pick_coord();
    int c, span;
    c = (sb.cell_mm == 0) ? 1 : sb.cell_mm;
    if (c >= 200 || $urandom_range(0, 199) == 0 && c >= 20) return 16'($urandom);
    span = (c * 170 > 32767) ? 32767 : c * 170;
    return 16'($urandom_range(0, 2 * span) - span);
  endfunction

  function automatic logic [15:0] pick_index();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55 && sb.touched.size() > 0)
      return 16'(sb.touched[$urandom_range(0, sb.touched.size() - 1)]);
    if (r < 75) return 16'($urandom);
    return 16'((HALF_SIDE + $urandom_range(0, 9) - 5) * GRID_SIDE
               + HALF_SIDE + $urandom_range(0, 9) - 5);
  endfunction

  task automatic send_random();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) send_word(OP_POINT, pick_coord(), pick_coord(), 16'($urandom));
    else if (r < 97) send_word(OP_READ, 16'($urandom), 16'($urandom), pick_index());
    else send_word(2'd3, 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic point_then_read(int x, int y);
    send_word(OP_POINT, 16'(x), 16'(y), '0);
    send_word(OP_READ, '0, '0, 16'(sb.touched[$]));
  endtask

  initial begin
    int cell_sizes [6] = '{5, 1, 1000, 0, 37, 0};
    int pillars [6] = '{300, 0, 4095, 4095, 1500, 0};
    repeat (9) @(negedge clk);
    rst_n = 1;

    // directed words at reset settings, then with cell size 1000
    send_word(OP_READ, '0, '0, 16'd0);
    send_word(OP_READ, '0, '0, 16'hFFFF);
    send_word(2'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    point_then_read(0, 0);
    point_then_read(-50, 200);
    point_then_read(200, -50);
    point_then_read(-200, -170);
    point_then_read(150, -200);
    point_then_read(-290, 5);
    point_then_read(40, 30);
    point_then_read(700, 20);
    point_then_read(-32768, 32767);
    send_word(OP_CLEAR, '0, '0, '0);
    send_word(OP_READ, '0, '0, 16'(HALF_SIDE * GRID_SIDE + HALF_SIDE));
    write_reg(2'd2, 12'hFFF);
    write_reg(2'd3, 12'h000);
    write_reg(CFG_CELL_SIZE, 12'd1000);
    point_then_read(32767, 32767);
    point_then_read(-32768, -32768);
    point_then_read(32767, -32768);

    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 5) begin
        cell_sizes[ph] = $urandom_range(2, 1000);
        pillars[ph] = $urandom_range(0, 4095);
      end
      write_reg(CFG_CELL_SIZE, 12'(cell_sizes[ph]));
      write_reg(CFG_PILLAR_RADIUS, 12'(pillars[ph]));
      if (ph == 2) send_word(OP_CLEAR, '0, '0, '0);
      for (int k = 0; k < 190; k++) begin
        case ((k / 24) % 4)
          0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
          1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
          2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
          default: begin send_idle_pct = 26; recv_stall_pct = 26; end
        endcase
        if (ph == 1 && k == 100) hold_req = 1;
        send_random();
      end
    end

    in_valid = 0;
    recv_stall_pct = 0;
    while (sb.cell_values_due.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (sb.errors == 0 && sb.cell_values_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
